@@ sv/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// shared types and constants for the sorted point set unit
// ----------------------------------------------------------------------------
package sps_pkg;

  // table geometry
  localparam int CAPACITY    = 256;
  localparam int COORD_BITS  = 32;
  localparam int HANDLE_BITS = 16;

  localparam int IDX_BITS    = $clog2(CAPACITY);
  localparam int CNT_BITS    = $clog2(CAPACITY + 1);
  localparam int KEY_BITS    = 2 * COORD_BITS;
  localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;

  // port field widths
  localparam int IN_COORD_W  = 32;
  localparam int IN_HANDLE_W = 16;
  localparam int SLOT_W      = 8;
  localparam int OUT_HANDLE_W = 16;
  localparam int COUNT_W     = 9;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 40;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_PROBE_CMP,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

  // compare unit result
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ sv/sps_ram.sv @@
// ----------------------------------------------------------------------------
// sps_ram
// simple dual-port table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 80
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/sps_keycmp.sv @@
// ----------------------------------------------------------------------------
// sps_keycmp
// shared key comparator used by the search steps and the hit probe
// ----------------------------------------------------------------------------
module sps_keycmp
  import sps_pkg::*;
(
  input  logic [KEY_BITS-1:0] entry_key,
  input  logic [KEY_BITS-1:0] probe_key,
  output cmp_res_t            res
);

  // keys are stored with flipped sign bits, so unsigned order is signed order
  always_comb begin
    res.lt = (entry_key < probe_key);
    res.eq = (entry_key == probe_key);
  end

endmodule

@@ sv/sorted_point_set_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_point_set_unit
// ordered point table with binary-search insert and lookup
// ----------------------------------------------------------------------------
// lookup: capture, binary search over the table, a probe read of the found slot, then the output register
// insert adds the one-entry-per-cycle shift and the store of the new entry
// one command in flight at a time
// every step is bounded by the single table read port (one registered read a cycle)
// synchronous active-low reset empties the table; entry contents are not cleared
module sorted_point_set_unit
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // point_x[31:0], point_y[63:32], point_handle[79:64]
  input  logic [0:0]            in_tuser,  // cmd[0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // slot_index[7:0], found_handle[23:8],
                                           // entry_count[32:24], zero fill[39:33]
  output logic [1:0]            out_tuser  // status[1:0]
);

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   lo_r, lo_nxt;
  logic [CNT_BITS-1:0]   hi_r, hi_nxt;
  logic [CNT_BITS-1:0]   idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  hit_r, hit_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [HANDLE_BITS-1:0] fhandle_r, fhandle_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [CNT_BITS-1:0]   res_slot_r, res_slot_nxt;

  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;

  logic                  in_beat;
  logic                  out_load;
  logic [CNT_BITS-1:0]   mid;
  logic [CNT_BITS-1:0]   shift_top;
  logic                  shift_more;

  logic                  ram_wr_en;
  logic [IDX_BITS-1:0]   ram_wr_addr;
  logic [ENTRY_BITS-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [IDX_BITS-1:0]   ram_rd_addr;
  logic [ENTRY_BITS-1:0] ram_rd_data;
  cmp_res_t              cmp;

  logic [COORD_BITS-1:0] in_x, in_y;

  // table storage
  sps_ram #(
    .ADDR_BITS (IDX_BITS),
    .DATA_BITS (ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // shared comparator
  sps_keycmp u_cmp (
    .entry_key (ram_rd_data[ENTRY_BITS-1:HANDLE_BITS]),
    .probe_key (key_r),
    .res       (cmp)
  );

  // handshakes
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_vld_r || out_tready);

  // search midpoint and shift bookkeeping
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign shift_top  = pend_r ? (idx_r - 1'b1) : idx_r;
  assign shift_more = (shift_top > lo_r);

  // incoming coordinates, low bits only
  assign in_x = in_tdata[COORD_BITS-1:0];
  assign in_y = in_tdata[IN_COORD_W+COORD_BITS-1:IN_COORD_W];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) state_nxt = S_SEARCH_RD;
      end
      S_SEARCH_RD: begin
        if (lo_r < hi_r) state_nxt = S_SEARCH_CMP;
        else if (lo_r < count_r) state_nxt = S_PROBE_CMP;
        else state_nxt = S_DECIDE;
      end
      S_SEARCH_CMP: state_nxt = S_SEARCH_RD;
      S_PROBE_CMP:  state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (cmd_r == CMD_INSERT && !hit_r && count_r < CNT_BITS'(CAPACITY)) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!pend_r && !shift_more) state_nxt = S_PLACE;
      end
      S_PLACE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r[IDX_BITS-1:0];
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = mid[IDX_BITS-1:0];
    unique case (state_r)
      S_SEARCH_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = (lo_r < hi_r) ? mid[IDX_BITS-1:0] : lo_r[IDX_BITS-1:0];
      end
      S_SHIFT: begin
        ram_wr_en   = pend_r;
        ram_rd_en   = shift_more;
        ram_rd_addr = IDX_BITS'(shift_top - 1'b1);
      end
      S_PLACE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = lo_r[IDX_BITS-1:0];
        ram_wr_data = {key_r, handle_r};
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    fhandle_nxt    = fhandle_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    unique case (state_r)
      S_IDLE: begin
        // capture the command and build order keys
        cmd_nxt    = cmd_t'(in_tuser[0]);
        key_nxt    = {~in_x[COORD_BITS-1], in_x[COORD_BITS-2:0],
                      ~in_y[COORD_BITS-1], in_y[COORD_BITS-2:0]};
        handle_nxt = in_tdata[2*IN_COORD_W+HANDLE_BITS-1:2*IN_COORD_W];
        lo_nxt     = '0;
        hi_nxt     = count_r;
        hit_nxt    = 1'b0;
      end
      S_SEARCH_CMP: begin
        if (cmp.lt) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
      end
      S_PROBE_CMP: begin
        hit_nxt     = cmp.eq;
        fhandle_nxt = ram_rd_data[HANDLE_BITS-1:0];
      end
      S_DECIDE: begin
        res_slot_nxt   = '0;
        res_status_nxt = ST_OK;
        fhandle_nxt    = '0;
        idx_nxt        = count_r;
        pend_nxt       = 1'b0;
        if (cmd_r == CMD_INSERT) begin
          if (hit_r) begin
            res_status_nxt = ST_DUP;
            res_slot_nxt   = lo_r;
          end else if (count_r >= CNT_BITS'(CAPACITY)) begin
            res_status_nxt = ST_FULL;
          end
        end else begin
          if (hit_r) begin
            res_slot_nxt = lo_r;
            fhandle_nxt  = fhandle_r;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        // write the entry read last cycle one slot up, read the next one down
        idx_nxt  = shift_top;
        pend_nxt = shift_more;
      end
      S_PLACE: begin
        count_nxt    = count_r + 1'b1;
        res_slot_nxt = lo_r;
      end
      default: begin
      end
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    handle_r     <= handle_nxt;
    fhandle_r    <= fhandle_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W - SLOT_W - OUT_HANDLE_W - COUNT_W)'(0),
                     COUNT_W'(count_r),
                     OUT_HANDLE_W'(fhandle_r),
                     res_slot_r[SLOT_W-1:0]};
      out_user_r <= res_status_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("ready held after input beat");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH_RD || state_r == S_SEARCH_CMP) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of order");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (out_tdata[32:24] == COUNT_W'(CAPACITY)))
    else $error("full status with table not full");

endmodule

@@ tb/sorted_point_set_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_point_set_unit_tb
// self-checking bench for the sorted point set unit
//
// Sends insert and lookup commands as input beats and checks every result
// beat against a behavioral bench copy of the point table or a hand-written
// result. A short directed table covers the empty table, the coordinate
// extremes, duplicates and lookup hits and misses. A long random run then
// fills the table to capacity, so later inserts come back full or
// duplicate. Both stream sides idle at random. The result side holds off
// once for a long stretch. The input side twice waits for every result.
// ----------------------------------------------------------------------------
module sorted_point_set_unit_tb
  import sps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1580;
  localparam int IDLE_PCT     = 13;
  localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int HOLD_AT      = 6000;  // sink cycle where the long hold-off starts
  localparam int HOLD_LEN     = 700;
  localparam int DRAIN_CYCLES = 300;   // quiet time after the last result, to watch for stray beats
  localparam int MAX_REPORTS  = 100;

  localparam logic [IN_COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [IN_COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;

  // one result beat, unpacked into its fields
  typedef struct {
    logic [SLOT_W-1:0]       slot;
    logic [OUT_HANDLE_W-1:0] handle;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } point_result_t;

  // one directed command, with a hand-written result where it is obvious
  typedef struct {
    cmd_t                   cmd;
    logic [IN_COORD_W-1:0]  x;
    logic [IN_COORD_W-1:0]  y;
    logic [IN_HANDLE_W-1:0] h;
    bit                     typed;
    point_result_t          want;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // point_x[31:0], point_y[63:32], point_handle[79:64]
  logic [0:0]            in_tuser   = '0;  // cmd[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // slot_index[7:0], found_handle[23:8],
                                           // entry_count[32:24], zero fill[39:33]
  logic [1:0]            out_tuser;        // status[1:0]

  // bench copy of the point table
  logic signed [COORD_BITS-1:0] table_x [CAPACITY];
  logic signed [COORD_BITS-1:0] table_y [CAPACITY];
  logic [HANDLE_BITS-1:0]       table_h [CAPACITY];
  int                           table_count = 0;

  point_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            error_count = 0;
  int            quiet_cycles = 0;
  int            sink_cycles = 0;
  int            hold_left = 0;
  bit            no_idle = 1'b0;

  sorted_point_set_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // apply one command to the bench table and return the result it gives
  function automatic point_result_t apply_point_cmd(input cmd_t c,
                                                    input logic signed [COORD_BITS-1:0] x,
                                                    input logic signed [COORD_BITS-1:0] y,
                                                    input logic [HANDLE_BITS-1:0] h);
    point_result_t r;
    int lo;
    int hi;
    int mid;
    bit hit;
    lo = 0;
    hi = table_count;
    // first slot not below (x, y), x first then y, both signed
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (table_x[mid] < x || (table_x[mid] == x && table_y[mid] < y)) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    hit = (lo < table_count) && (table_x[lo] == x) && (table_y[lo] == y);
    r.slot   = '0;
    r.handle = '0;
    r.status = ST_OK;
    if (c == CMD_INSERT) begin
      if (hit) begin
        r.status = ST_DUP;
        r.slot   = SLOT_W'(lo);
      end else if (table_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // open a gap at lo and store the point there
        for (int i = table_count; i > lo; i--) begin
          table_x[i] = table_x[i-1];
          table_y[i] = table_y[i-1];
          table_h[i] = table_h[i-1];
        end
        table_x[lo] = x;
        table_y[lo] = y;
        table_h[lo] = h;
        table_count++;
        r.slot = SLOT_W'(lo);
      end
    end else if (hit) begin
      r.slot   = SLOT_W'(lo);
      r.handle = table_h[lo];
    end else begin
      r.status = ST_NOT_FOUND;
    end
    r.count = COUNT_W'(table_count);
    return r;
  endfunction

  // coordinate from random bits, a small cluster, an extreme or a held value
  function automatic logic [IN_COORD_W-1:0] pick_coord(input logic [IN_COORD_W-1:0] held);
    logic [IN_COORD_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 4))
          0: v = COORD_MIN;
          1: v = COORD_MAX;
          2: v = '1;
          3: v = '0;
          default: v = 1;
        endcase
      end
      default: v = held;
    endcase
    return v;
  endfunction

  task automatic add_row(input cmd_t c, input logic [IN_COORD_W-1:0] x,
                         input logic [IN_COORD_W-1:0] y, input logic [IN_HANDLE_W-1:0] h,
                         input bit typed, input int slot, input int fh,
                         input status_t st, input int cnt);
    stim_row_t row;
    row.cmd         = c;
    row.x           = x;
    row.y           = y;
    row.h           = h;
    row.typed       = typed;
    row.want.slot   = SLOT_W'(slot);
    row.want.handle = OUT_HANDLE_W'(fh);
    row.want.status = st;
    row.want.count  = COUNT_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // offer one command beat and record its expected result once accepted
  task automatic send_point(input cmd_t c, input logic [IN_COORD_W-1:0] x,
                            input logic [IN_COORD_W-1:0] y, input logic [IN_HANDLE_W-1:0] h,
                            input bit typed, input point_result_t want);
    point_result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {h, y, x};
    in_tuser  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_point_cmd(c, x, y, h);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // hold the input side until every result is back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    point_result_t none;
    logic [IN_COORD_W-1:0] hx;
    logic [IN_COORD_W-1:0] hy;
    int pick;
    int held;
    none = '{default: '0, status: ST_OK};

    // directed rows: empty table, extremes, duplicates, hits and misses
    add_row(CMD_LOOKUP, 0, 0, 16'h0000, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(CMD_INSERT, 0, 0, 16'h1234, 1, 0, 0, ST_OK, 1);
    add_row(CMD_INSERT, COORD_MIN, COORD_MIN, 16'hFFFF, 1, 0, 0, ST_OK, 2);
    add_row(CMD_INSERT, COORD_MAX, COORD_MAX, 16'h0000, 1, 2, 0, ST_OK, 3);
    add_row(CMD_INSERT, COORD_MAX, COORD_MIN, 16'hA5A5, 1, 2, 0, ST_OK, 4);
    add_row(CMD_INSERT, COORD_MIN, COORD_MAX, 16'h5A5A, 1, 1, 0, ST_OK, 5);
    add_row(CMD_INSERT, 0, 0, 16'h7777, 1, 2, 0, ST_DUP, 5);
    add_row(CMD_LOOKUP, COORD_MAX, COORD_MAX, 16'hFFFF, 1, 4, 16'h0000, ST_OK, 5);
    add_row(CMD_LOOKUP, COORD_MIN, COORD_MIN, 16'h0000, 1, 0, 16'hFFFF, ST_OK, 5);
    add_row(CMD_LOOKUP, COORD_MIN, COORD_MAX, 16'h0000, 1, 1, 16'h5A5A, ST_OK, 5);
    add_row(CMD_LOOKUP, 0, 1, 16'h0000, 1, 0, 0, ST_NOT_FOUND, 5);
    add_row(CMD_LOOKUP, COORD_MAX, COORD_MIN + 1, 16'h0000, 0, 0, 0, ST_OK, 0);
    add_row(CMD_INSERT, '1, 5, 16'h0F0F, 0, 0, 0, ST_OK, 0);
    add_row(CMD_INSERT, 1, -5, 16'hF0F0, 0, 0, 0, ST_OK, 0);
    add_row(CMD_INSERT, 0, '1, 16'h8001, 0, 0, 0, ST_OK, 0);
    add_row(CMD_INSERT, 0, 1, 16'h0001, 0, 0, 0, ST_OK, 0);
    add_row(CMD_LOOKUP, 0, '1, 16'h0000, 0, 0, 0, ST_OK, 0);
    add_row(CMD_LOOKUP, '1, 5, 16'h0000, 0, 0, 0, ST_OK, 0);
    add_row(CMD_INSERT, COORD_MIN, 0, 16'hC3C3, 0, 0, 0, ST_OK, 0);
    add_row(CMD_INSERT, COORD_MAX, COORD_MAX, 16'hFFFF, 0, 0, 0, ST_OK, 0);
    add_row(CMD_LOOKUP, 0, 0, 16'h0000, 0, 0, 0, ST_OK, 0);
    add_row(CMD_LOOKUP, COORD_MAX - 1, 0, 16'h0000, 0, 0, 0, ST_OK, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                 directed_rows[i].h, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_results();

    // random commands, table fills up part way through
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle <= (n >= 700 && n < 1000);
      if (n == 400) wait_for_results();
      held = (table_count > 0) ? $urandom_range(0, table_count - 1) : 0;
      hx   = (table_count > 0) ? table_x[held] : $urandom;
      hy   = (table_count > 0) ? table_y[held] : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_point(CMD_INSERT, pick_coord(hx), pick_coord(hy), IN_HANDLE_W'($urandom), 0,
                   none);
      end else if (pick < 65) begin
        send_point(CMD_LOOKUP, hx, hy, IN_HANDLE_W'($urandom), 0, none);
      end else if (pick < 80) begin
        send_point(CMD_LOOKUP, pick_coord(hx), pick_coord(hy), IN_HANDLE_W'($urandom), 0,
                   none);
      end else begin
        send_point(CMD_INSERT, hx, hy, IN_HANDLE_W'($urandom), 0, none);
      end
    end
    in_tvalid <= 1'b0;

    // let the last results drain, then watch for stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[sorted_point_set_unit] OK");
    end else begin
      $display("[sorted_point_set_unit] ERROR");
    end
    $finish;
  end

  // result sink: random ready, one long hold-off
  always @(posedge clk) begin
    sink_cycles <= sink_cycles + 1;
    if (sink_cycles == HOLD_AT) begin
      hold_left  <= HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    point_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: unexpected result beat, data %h status %0d",
                   $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[7:0] !== want.slot) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: slot_index expected %0d actual %0d",
                     $time, want.slot, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[23:8] !== want.handle) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: found_handle expected %h actual %h",
                     $time, want.handle, out_tdata[23:8]);
          error_count++;
        end
        if (out_tuser !== want.status) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[32:24] !== want.count) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, out_tdata[32:24]);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("[sorted_point_set_unit] ERROR");
      $finish;
    end
  end

endmodule
